/* design/multi_pattern_string_matcher_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the multi-pattern string matcher
// Shared helpers for concurrent checks in the design files.
// ----------------------------------------------------------------------------
`ifndef MULTI_PATTERN_STRING_MATCHER_DEFINES_SVH
`define MULTI_PATTERN_STRING_MATCHER_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define MPSM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define MPSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/mpsm_pkg.sv */
// ----------------------------------------------------------------------------
// mpsm_pkg
// Types and constants shared by the matcher controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package mpsm_pkg;
    localparam int MaxNodes  = 1024;
    localparam int Alphabet  = 256;
    localparam int NodeW     = $clog2(MaxNodes);
    localparam int SymW      = $clog2(Alphabet);
    localparam int CountW    = 10;
    localparam int GotoAw    = NodeW + SymW;
    localparam logic [CountW-1:0] CountMax = '1;

    localparam logic [1:0] CMD_PATTERN = 2'd0;
    localparam logic [1:0] CMD_BUILD   = 2'd1;
    localparam logic [1:0] CMD_SCAN    = 2'd2;

    // Datapath operations requested by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,        // clear one goto row entry at clear address
        OP_INS_RD,       // read goto(insert_cursor, sym)
        OP_INS_WR,       // create node or advance cursor
        OP_BLD_INIT,     // reset queue, push root
        OP_BLD_POP,      // pop node u, sym counter := 0
        OP_BLD_RD,       // read goto(u, sym)
        OP_BLD_CHK,      // inspect child; start failure search
        OP_BLD_FRD,      // read goto(f, sym)
        OP_BLD_FCHK,     // inspect candidate
        OP_BLD_FNEXT,    // f := fail(f)
        OP_SCN_RD,       // read goto(p, sym)
        OP_SCN_CHK,      // decide: take edge or follow link
        OP_SCN_WALK,     // walk match chain one node
        OP_DONE          // latch result
    } op_t;

    typedef struct packed {
        op_t              op;
        logic             load_item;
    } cmd_t;

    typedef struct packed {
        logic clear_last;    // last goto entry is being cleared
        logic edge_zero;     // registered goto read is zero
        logic queue_empty;   // no node left in build queue
        logic sym_last;      // symbol counter at last symbol
        logic u_is_root;     // popped node is root
        logic f_is_root;     // failure search at root
        logic p_is_root;     // scan node is root
        logic walk_stop;     // match chain walk ends here
        logic [1:0] command; // latched command
    } stat_t;
endpackage
`default_nettype wire

/* design/mpsm_datapath.sv */
// ----------------------------------------------------------------------------
// mpsm_datapath
// Goto memory, node stores, build queue and counters of the matcher.
// ----------------------------------------------------------------------------
`default_nettype none
`include "multi_pattern_string_matcher_defines.svh"
module mpsm_datapath (
    input  wire                          clk,
    input  wire                          rst_n,
    input  mpsm_pkg::cmd_t               cmd,
    output mpsm_pkg::stat_t              stat,
    input  wire [1:0]                    in_command,
    input  wire [mpsm_pkg::SymW-1:0]     in_symbol,
    input  wire                          in_last,
    output logic [mpsm_pkg::CountW-1:0]  res_new,
    output logic [mpsm_pkg::CountW-1:0]  res_total,
    output logic                         res_status
);
    import mpsm_pkg::*;

    // Memories.
    logic [NodeW-1:0] goto_mem  [2**GotoAw];
    logic [NodeW-1:0] fail_mem  [MaxNodes];
    logic [NodeW-1:0] queue_mem [MaxNodes];
    logic             term_mem  [MaxNodes];
    logic             vis_mem   [MaxNodes];

    logic [1:0]        command_reg;
    logic [SymW-1:0]   sym_reg;
    logic              last_reg;
    logic [NodeW:0]    node_count_reg;
    logic [NodeW-1:0]  cursor_reg;
    logic [NodeW-1:0]  scan_reg;
    logic [NodeW:0]    head_reg;
    logic [NodeW:0]    tail_reg;
    logic [CountW-1:0] total_reg;
    logic [CountW-1:0] found_reg;
    logic              drop_reg;
    logic [GotoAw:0]   clr_reg;
    logic [NodeW-1:0]  u_reg;
    logic [NodeW-1:0]  f_reg;
    logic [SymW-1:0]   bsym_reg;
    logic [NodeW-1:0]  child_reg;
    logic [NodeW-1:0]  t_reg;

    // Registered memory reads.
    logic [NodeW-1:0]  gdata_reg;
    logic [NodeW-1:0]  fdata_reg;
    logic [NodeW-1:0]  qdata_reg;
    logic              term_rd_reg;
    logic              vis_rd_reg;

    logic [GotoAw-1:0] g_raddr;
    logic [NodeW-1:0]  f_raddr;
    logic              g_we;
    logic [GotoAw-1:0] g_waddr;
    logic [NodeW-1:0]  g_wdata;
    logic              f_we;
    logic [NodeW-1:0]  f_waddr;
    logic [NodeW-1:0]  f_wdata;
    logic              q_we;
    logic [NodeW-1:0]  t_raddr;
    logic              term_we;
    logic [NodeW-1:0]  term_waddr;
    logic              term_wdata;
    logic              vis_we;
    logic [NodeW-1:0]  vis_waddr;
    logic              vis_wdata;
    logic              full;
    logic [CountW:0]   sum;

    assign full = (node_count_reg == (NodeW+1)'(MaxNodes));

    // Read address selection per operation.
    // A scan reads the failure link of the scan node on a goto read and of the chain node otherwise; a build that of f.
    always_comb
    begin
        g_raddr = {cursor_reg, sym_reg};
        f_raddr = (command_reg == CMD_SCAN) ? t_reg : f_reg;
        t_raddr = t_reg;
        case (cmd.op)
            OP_INS_RD:  g_raddr = {cursor_reg, sym_reg};
            OP_BLD_RD:  g_raddr = {u_reg, bsym_reg};
            OP_BLD_FRD: g_raddr = {f_reg, bsym_reg};
            OP_SCN_RD:
            begin
                g_raddr = {scan_reg, sym_reg};
                f_raddr = scan_reg;
            end
            default:    g_raddr = {cursor_reg, sym_reg};
        endcase
    end

    // Write port selection.
    always_comb
    begin
        g_we = 1'b0; g_waddr = clr_reg[GotoAw-1:0]; g_wdata = '0;
        f_we = 1'b0; f_waddr = '0; f_wdata = '0;
        q_we = 1'b0;
        term_we = 1'b0; term_waddr = '0; term_wdata = 1'b0;
        vis_we = 1'b0; vis_waddr = '0; vis_wdata = 1'b0;
        case (cmd.op)
            OP_CLEAR:
            begin
                g_we = 1'b1;
                term_we = 1'b1; term_waddr = clr_reg[NodeW-1:0];
                vis_we = 1'b1;  vis_waddr = clr_reg[NodeW-1:0];
            end
            OP_INS_WR:
            begin
                if (gdata_reg == '0 && !full) begin
                    g_we = 1'b1; g_waddr = {cursor_reg, sym_reg};
                    g_wdata = node_count_reg[NodeW-1:0];
                    f_we = 1'b1; f_waddr = node_count_reg[NodeW-1:0];
                    term_we = 1'b1; term_waddr = node_count_reg[NodeW-1:0];
                    term_wdata = last_reg;
                    vis_we = 1'b1; vis_waddr = node_count_reg[NodeW-1:0];
                end else if (gdata_reg != '0 && last_reg) begin
                    term_we = 1'b1; term_waddr = gdata_reg; term_wdata = 1'b1;
                end
            end
            OP_BLD_INIT:
            begin
                f_we = 1'b1; q_we = 1'b1;
            end
            OP_BLD_CHK:
            begin
                if (gdata_reg != '0) begin
                    f_we = 1'b1; f_waddr = gdata_reg;
                    q_we = (tail_reg < (NodeW+1)'(MaxNodes));
                end
            end
            OP_BLD_FCHK:
            begin
                if (gdata_reg != '0) begin
                    f_we = 1'b1; f_waddr = child_reg; f_wdata = gdata_reg;
                end
            end
            OP_SCN_WALK:
            begin
                if (!stat.walk_stop) begin
                    vis_we = 1'b1; vis_waddr = t_reg; vis_wdata = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Memory ports; read data is registered.
    always_ff @(posedge clk)
    begin
        if (g_we)
            goto_mem[g_waddr] <= g_wdata;
        gdata_reg <= goto_mem[g_raddr];
        if (f_we)
            fail_mem[f_waddr] <= f_wdata;
        fdata_reg <= fail_mem[f_raddr];
        if (q_we)
            queue_mem[tail_reg[NodeW-1:0]] <= (cmd.op == OP_BLD_INIT) ? '0 : gdata_reg;
        qdata_reg <= queue_mem[head_reg[NodeW-1:0]];
        if (term_we)
            term_mem[term_waddr] <= term_wdata;
        term_rd_reg <= term_mem[t_raddr];
        if (vis_we)
            vis_mem[vis_waddr] <= vis_wdata;
        vis_rd_reg <= vis_mem[t_raddr];
    end

    assign sum = {1'b0, total_reg} + {1'b0, found_reg};

    // Control and working registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            command_reg <= '0; sym_reg <= '0; last_reg <= 1'b0;
            node_count_reg <= (NodeW+1)'(1);
            cursor_reg <= '0; scan_reg <= '0;
            head_reg <= '0; tail_reg <= '0;
            total_reg <= '0; found_reg <= '0; drop_reg <= 1'b0; clr_reg <= '0;
            u_reg <= '0; f_reg <= '0; bsym_reg <= '0;
            child_reg <= '0; t_reg <= '0;
            res_new <= '0; res_total <= '0; res_status <= 1'b0;
        end else begin
            if (cmd.load_item) begin
                command_reg <= in_command; sym_reg <= in_symbol; last_reg <= in_last;
                found_reg <= '0;
            end
            case (cmd.op)
                OP_CLEAR: clr_reg <= clr_reg + 1'b1;
                OP_INS_WR:
                begin
                    drop_reg <= 1'b0;
                    if (gdata_reg == '0) begin
                        if (!full) begin
                            cursor_reg <= last_reg ? '0 : node_count_reg[NodeW-1:0];
                            node_count_reg <= node_count_reg + 1'b1;
                        end else begin
                            drop_reg <= 1'b1;
                            if (last_reg) cursor_reg <= '0;
                        end
                    end else begin
                        cursor_reg <= last_reg ? '0 : gdata_reg;
                    end
                end
                OP_BLD_INIT:
                begin
                    head_reg <= '0; tail_reg <= (NodeW+1)'(1);
                end
                OP_BLD_POP:
                begin
                    u_reg <= qdata_reg; head_reg <= head_reg + 1'b1;
                    bsym_reg <= '0;
                end
                OP_BLD_CHK:
                begin
                    child_reg <= gdata_reg;
                    f_reg <= u_reg;
                    if (gdata_reg != '0 && tail_reg < (NodeW+1)'(MaxNodes))
                        tail_reg <= tail_reg + 1'b1;
                    // The symbol is finished unless a failure search starts.
                    if (gdata_reg == '0 || u_reg == '0)
                        bsym_reg <= bsym_reg + 1'b1;
                end
                OP_BLD_FCHK:
                begin
                    // The search ends on a found edge or at the root.
                    if (gdata_reg != '0 || f_reg == '0)
                        bsym_reg <= bsym_reg + 1'b1;
                end
                OP_BLD_FNEXT: f_reg <= fdata_reg;
                OP_SCN_CHK:
                begin
                    if (gdata_reg != '0 || scan_reg == '0) begin
                        scan_reg <= gdata_reg; t_reg <= gdata_reg;
                    end else begin
                        scan_reg <= fdata_reg;
                    end
                end
                OP_SCN_WALK:
                begin
                    if (!stat.walk_stop) begin
                        if (term_rd_reg && found_reg != CountMax)
                            found_reg <= found_reg + 1'b1;
                        t_reg <= fdata_reg;
                    end
                end
                OP_DONE:
                begin
                    res_new <= (command_reg == CMD_SCAN) ? found_reg : '0;
                    if (command_reg == CMD_SCAN) begin
                        total_reg <= sum[CountW] ? CountMax : sum[CountW-1:0];
                        res_total <= sum[CountW] ? CountMax : sum[CountW-1:0];
                    end else begin
                        res_total <= total_reg;
                    end
                    res_status <= (command_reg == CMD_PATTERN) && drop_reg;
                end
                default: ;
            endcase
        end
    end

    // Status flags for the controller.
    always_comb
    begin
        stat.clear_last  = (clr_reg == (GotoAw+1)'(2**GotoAw - 1));
        stat.edge_zero   = (gdata_reg == '0);
        stat.queue_empty = !(head_reg < tail_reg && head_reg < (NodeW+1)'(MaxNodes));
        stat.sym_last    = (bsym_reg == SymW'(Alphabet - 1));
        stat.u_is_root   = (u_reg == '0);
        stat.f_is_root   = (f_reg == '0);
        stat.p_is_root   = (scan_reg == '0);
        stat.walk_stop   = (t_reg == '0) || vis_rd_reg;
        stat.command     = command_reg;
    end

    `MPSM_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1,
        node_count_reg <= (NodeW+1)'(MaxNodes) && node_count_reg != '0,
        "node count out of range")
    `MPSM_ASSERT_IMP(a_queue_order, clk, rst_n, 1'b1, head_reg <= tail_reg,
        "build queue head passed tail")
    `MPSM_ASSERT_NEXT(a_total_mono, clk, rst_n, cmd.op != OP_CLEAR,
        total_reg >= $past(total_reg), "match total decreased")
endmodule
`default_nettype wire

/* design/mpsm_ctrl.sv */
// ----------------------------------------------------------------------------
// mpsm_ctrl
// Sequencer for insertion, failure-link build and text scan.
// ----------------------------------------------------------------------------
`default_nettype none
`include "multi_pattern_string_matcher_defines.svh"
module mpsm_ctrl (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  wire             m_tready,
    output mpsm_pkg::cmd_t  cmd,
    input  mpsm_pkg::stat_t stat
);
    import mpsm_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DISP  = 4'd2;
    localparam logic [3:0] S_INSW  = 4'd3;
    localparam logic [3:0] S_POP   = 4'd4;
    localparam logic [3:0] S_BRD   = 4'd5;
    localparam logic [3:0] S_BWAIT = 4'd6;
    localparam logic [3:0] S_BCHK  = 4'd7;
    localparam logic [3:0] S_FRD   = 4'd8;
    localparam logic [3:0] S_FWAIT = 4'd9;
    localparam logic [3:0] S_FCHK  = 4'd10;
    localparam logic [3:0] S_SRD   = 4'd11;
    localparam logic [3:0] S_SCHK  = 4'd12;
    localparam logic [3:0] S_WALK  = 4'd13;
    localparam logic [3:0] S_WWAIT = 4'd14;
    localparam logic [3:0] S_DONE  = 4'd15;

    logic [3:0] state_reg, state_next;
    logic       out_reg, out_next;
    logic       popwait_reg, popwait_next;
    logic       wait_reg, wait_next;
    logic       advance;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_reg;

    always_comb
    begin
        state_next = state_reg;
        out_next = out_reg && !m_tready;
        popwait_next = 1'b0;
        wait_next = 1'b0;
        advance = 1'b0;
        cmd.op = OP_NONE;
        cmd.load_item = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                if (stat.clear_last) state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (s_tvalid && s_tready) begin
                    cmd.load_item = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                // Item registered; start the chosen operation.
                unique case (stat.command)
                    CMD_PATTERN: begin cmd.op = OP_INS_RD; state_next = S_INSW; end
                    CMD_BUILD:   begin cmd.op = OP_BLD_INIT; state_next = S_POP; end
                    CMD_SCAN:    begin cmd.op = OP_SCN_RD; state_next = S_SCHK; end
                    default:     state_next = S_DONE;
                endcase
                wait_next = 1'b1;
            end
            S_INSW:
            begin
                cmd.op = OP_INS_WR;
                state_next = S_DONE;
            end
            S_POP:
            begin
                // Queue read data is registered in a wait pass before the pop.
                if (!popwait_reg) begin
                    popwait_next = 1'b1;
                end else if (stat.queue_empty) begin
                    state_next = S_DONE;
                end else begin
                    cmd.op = OP_BLD_POP;
                    state_next = S_BRD;
                end
            end
            S_BRD:
            begin
                cmd.op = OP_BLD_RD;
                state_next = S_BCHK;
            end
            S_BCHK:
            begin
                cmd.op = OP_BLD_CHK;
                if (!stat.edge_zero && !stat.u_is_root) state_next = S_FRD;
                else advance = 1'b1;
            end
            S_FRD:
            begin
                // f_reg holds u (or the last candidate); step to its failure link first.
                if (!wait_reg) begin
                    wait_next = 1'b1;
                end else begin
                    cmd.op = OP_BLD_FNEXT;
                    state_next = S_FWAIT;
                end
            end
            S_FWAIT:
            begin
                cmd.op = OP_BLD_FRD;
                state_next = S_FCHK;
            end
            S_FCHK:
            begin
                cmd.op = OP_BLD_FCHK;
                if (!stat.edge_zero || stat.f_is_root) advance = 1'b1;
                else state_next = S_FRD;
            end
            S_SRD:
            begin
                // Goto and failure reads land in the next cycle.
                cmd.op = OP_SCN_RD;
                wait_next = 1'b1;
                state_next = S_SCHK;
            end
            S_SCHK:
            begin
                if (!wait_reg) begin
                    wait_next = 1'b1;
                end else begin
                    cmd.op = OP_SCN_CHK;
                    if (!stat.edge_zero || stat.p_is_root) state_next = S_WALK;
                    else state_next = S_SRD;
                end
            end
            S_WALK:
            begin
                // Let the registered node store reads return t's marks.
                state_next = S_WWAIT;
            end
            S_WWAIT:
            begin
                cmd.op = OP_SCN_WALK;
                if (stat.walk_stop) state_next = S_DONE;
                else state_next = S_WALK;
            end
            S_DONE:
            begin
                // Hold the new result back while the previous one waits.
                if (!out_reg || m_tready) begin
                    cmd.op = OP_DONE;
                    out_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
        if (advance) begin
            if (stat.sym_last) state_next = S_POP;
            else state_next = S_BRD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_CLEAR;
            out_reg <= 1'b0;
            popwait_reg <= 1'b0;
            wait_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            out_reg <= out_next;
            popwait_reg <= popwait_next;
            wait_reg <= wait_next;
        end
    end

    `MPSM_ASSERT_IMP(a_ready_idle, clk, rst_n, s_tready, state_reg == S_IDLE,
        "input ready outside idle")
    `MPSM_ASSERT_NEXT(a_done_valid, clk, rst_n, state_reg == S_DONE, m_tvalid,
        "result not presented after completion")
    `MPSM_ASSERT_NEXT(a_hold_result, clk, rst_n, m_tvalid && !m_tready, m_tvalid,
        "result withdrawn while stalled")
endmodule
`default_nettype wire

/* design/multi_pattern_string_matcher.sv */
// ----------------------------------------------------------------------------
// multi_pattern_string_matcher
// Aho-Corasick keyword matcher with goto memory and failure-link builder.
// ----------------------------------------------------------------------------
// Usage: each input transaction on s_* carries a command, a symbol and a
// pattern end flag. Pattern bytes extend the trie, a build command computes
// all failure links, and text bytes are scanned. Every input transaction
// gives exactly one output transaction on m_* with the new match count,
// the running total and a store-full status.
// A pattern byte reads its goto entry, then creates a node or advances;
// a text byte reads its goto entry and failure link, follows failure
// links until an edge or the root, then walks newly visited nodes on the
// match chain; a build pops each queued node, reads the goto entry of
// each of its 256 symbols and follows failure links for children below root.
// A new transaction is taken only after the previous one is processed.
// After reset the goto memory and node marks are cleared one entry per
// cycle over all 262144 goto entries; s_tready stays low until that pass ends.
// While m_tready is low the result holds; one more transaction is taken
// and processed, and its result waits until the held one is accepted.
// ----------------------------------------------------------------------------
`default_nettype none
module multi_pattern_string_matcher (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,  // [1:0] command, [9:2] symbol, [10] pattern_end
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata   // [9:0] new_matches, [19:10] total_matches, [20] status
);
    import mpsm_pkg::*;

    cmd_t              cmd;
    stat_t             stat;
    logic [CountW-1:0] res_new;
    logic [CountW-1:0] res_total;
    logic              res_status;

    mpsm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cmd(cmd), .stat(stat)
    );

    mpsm_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .in_command(s_tdata[1:0]), .in_symbol(s_tdata[9:2]), .in_last(s_tdata[10]),
        .res_new(res_new), .res_total(res_total), .res_status(res_status)
    );

    assign m_tdata = {3'b000, res_status, res_total, res_new};
endmodule
`default_nettype wire
